@@ rtl/core/udcd_pkg.sv @@
// Package for the uplink deframer and command decoder.
// Holds widths, header and command bytes, register indexes, the action codes and
// the command classifier. No dependencies.
package udcd_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned COUNT_W       = 8;
  localparam int unsigned ACTION_W      = 4;
  localparam int unsigned CFG_IDX_W     = 8;
  localparam int unsigned CFG_DATA_W    = 8;
  localparam int unsigned MAX_PAYLOAD_DEF = 128;

  localparam logic [BYTE_W-1:0] FLAG_BYTE  = 8'h7E;
  localparam logic [BYTE_W-1:0] HDR_BYTE   = 8'h42;
  localparam logic [BYTE_W-1:0] CMD_BURST  = 8'h77;
  localparam logic [BYTE_W-1:0] CMD_BEACON = 8'h20;
  localparam logic [BYTE_W-1:0] CMD_HK     = 8'h30;
  localparam logic [BYTE_W-1:0] CMD_KEEP   = 8'hAA;

  localparam logic [CFG_IDX_W-1:0] REG_TX_ENABLE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_ENABLE = 8'd1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_EMPTY         = 4'd0,
    ACT_UNKNOWN       = 4'd1,
    ACT_BURST         = 4'd2,
    ACT_BURST_BLOCKED = 4'd3,
    ACT_CARRIER_ONLY  = 4'd4,
    ACT_BEACON        = 4'd5,
    ACT_BEACON_BLOCKED = 4'd6,
    ACT_HOUSEKEEPING  = 4'd7,
    ACT_KEEPALIVE     = 4'd8
  } action_e;

  // Parser phase, one-hot.
  typedef enum logic [3:0] {
    PH_FLAG1   = 4'b0001,
    PH_FLAG2   = 4'b0010,
    PH_HDR     = 4'b0100,
    PH_PAYLOAD = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [BYTE_W-1:0]  command_code;
    logic [COUNT_W-1:0] payload_length;
    action_e            action;
  } result_t;

  function automatic action_e classify(input logic [BYTE_W-1:0] cmd,
                                       input logic tx_en, input logic mod_en);
    action_e act;
    act = ACT_UNKNOWN;
    case (cmd)
      CMD_BURST: begin
        if (!tx_en) act = ACT_BURST_BLOCKED;
        else if (!mod_en) act = ACT_CARRIER_ONLY;
        else act = ACT_BURST;
      end
      CMD_BEACON: act = tx_en ? ACT_BEACON : ACT_BEACON_BLOCKED;
      CMD_HK:     act = ACT_HOUSEKEEPING;
      CMD_KEEP:   act = ACT_KEEPALIVE;
      default:    act = ACT_UNKNOWN;
    endcase
    return act;
  endfunction

endpackage

@@ rtl/core/udcd_if.sv @@
// Handshake interfaces of the uplink deframer: received bytes, decoded frames
// and register writes. Depends on udcd_pkg.
interface udcd_byte_if import udcd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface udcd_frame_if import udcd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  command_code;
  logic [COUNT_W-1:0] payload_length;
  logic [ACTION_W-1:0] action;

  modport source (output valid, output command_code, output payload_length,
                  output action, input ready);
  modport sink   (input valid, input command_code, input payload_length,
                  input action, output ready);
endinterface

interface udcd_cfg_if import udcd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/uplink_deframer_command_decoder.sv @@
// Uplink deframer and command decoder: top level and only module.
// Depends on udcd_pkg and the interfaces in udcd_if.sv.
//
//  Channel  Direction  Payload                                  Accepted when
//  rx_i     in         rx_byte                                  valid && ready
//  frame_o  out        command_code, payload_length, action     valid && ready
//  cfg_i    in         index (0 tx_enable, 1 mod_enable), data  valid && ready
//
// One byte is taken per cycle while rx_i is not stalled; the parser state and a
// two-entry result buffer are updated in that same cycle, and a decoded frame is
// registered into the result buffer as its closing flag is taken. rx_i stalls
// only when both result entries are held. cfg_i is always ready. Reset sets both
// enables, hunts for the first flag and empties the result buffer.
module uplink_deframer_command_decoder import udcd_pkg::*; #(
  parameter int unsigned MaxPayload = MAX_PAYLOAD_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  udcd_byte_if.sink     rx_i,
  udcd_frame_if.source  frame_o,
  udcd_cfg_if.sink      cfg_i
);

  localparam logic [COUNT_W-1:0] MaxCount = COUNT_W'(MaxPayload);

  phase_e              phase_q, phase_d;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic [BYTE_W-1:0]   first_q;
  logic                first_we;
  logic                tx_en_q, mod_en_q;

  result_t             out_q, skid_q, res_new;
  logic                out_valid_q, skid_valid_q;
  logic                accept, emit, push, pop;

  assign rx_i.ready  = !skid_valid_q;
  assign cfg_i.ready = 1'b1;
  assign accept      = rx_i.valid && rx_i.ready;

  // Parser next state.
  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    first_we = 1'b0;
    emit     = 1'b0;
    res_new  = '{command_code: '0, payload_length: '0, action: ACT_EMPTY};
    case (phase_q)
      PH_FLAG1: begin
        if (rx_i.rx_byte == FLAG_BYTE) phase_d = PH_FLAG2;
      end
      PH_FLAG2: begin
        phase_d = (rx_i.rx_byte == FLAG_BYTE) ? PH_HDR : PH_FLAG1;
      end
      PH_HDR: begin
        if (rx_i.rx_byte == HDR_BYTE) begin
          count_d = '0;
          phase_d = PH_PAYLOAD;
        end else begin
          phase_d = PH_FLAG1;
        end
      end
      PH_PAYLOAD: begin
        if (rx_i.rx_byte == FLAG_BYTE) begin
          phase_d = PH_FLAG1;
          emit    = 1'b1;
          if (count_q != '0) begin
            res_new.command_code   = first_q;
            res_new.payload_length = count_q;
            res_new.action         = classify(first_q, tx_en_q, mod_en_q);
          end
        end else if (count_q < MaxCount) begin
          first_we = (count_q == '0);
          count_d  = count_q + COUNT_W'(1);
        end else begin
          // Overlong payload: the frame is dropped without a result.
          count_d = '0;
          phase_d = PH_FLAG1;
        end
      end
      default: begin
        phase_d = PH_FLAG1;
      end
    endcase
  end

  assign push = accept && emit;
  assign pop  = out_valid_q && frame_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_FLAG1;
      count_q      <= '0;
      tx_en_q      <= 1'b1;
      mod_en_q     <= 1'b1;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        count_q <= count_d;
      end
      if (cfg_i.valid) begin
        if (cfg_i.index == REG_TX_ENABLE) tx_en_q <= cfg_i.data[0];
        else if (cfg_i.index == REG_MOD_ENABLE) mod_en_q <= cfg_i.data[0];
      end
      // A push never coincides with a held skid entry, since rx_i is stalled then.
      if (pop) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= push;
        end
      end else if (push) begin
        if (out_valid_q) skid_valid_q <= 1'b1;
        else out_valid_q <= 1'b1;
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    if (accept && first_we) first_q <= rx_i.rx_byte;
    if (pop) begin
      if (skid_valid_q) out_q <= skid_q;
      else if (push) out_q <= res_new;
    end else if (push) begin
      if (out_valid_q) skid_q <= res_new;
      else out_q <= res_new;
    end
  end

  assign frame_o.valid          = out_valid_q;
  assign frame_o.command_code   = out_q.command_code;
  assign frame_o.payload_length = out_q.payload_length;
  assign frame_o.action         = out_q.action;

endmodule
